// ----- rtl/core/aes128ke_pkg.sv -----
`timescale 1ns / 1ps

package aes128ke_pkg;

  localparam int unsigned SCHED_WORDS = 44;
  localparam int unsigned IDX_W       = 6;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned RCON_IDX_W  = 4;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SCHED_WORDS - 1);

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    logic                  load;
    logic                  emit;
    logic                  last;
    logic [RCON_IDX_W-1:0] rcon_idx;
    logic                  rot_en;
  } seq_ctl_t;

  localparam logic [7:0] SBOX_TAB [0:255] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,
    8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,
    8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,
    8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,
    8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,
    8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,
    8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,
    8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,
    8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,
    8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,
    8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,
    8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,
    8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,
    8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,
    8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,
    8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,
    8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] rcon(input logic [RCON_IDX_W-1:0] idx);
    logic [7:0] r;
    case (idx)
      4'd0:    r = 8'h01;
      4'd1:    r = 8'h02;
      4'd2:    r = 8'h04;
      4'd3:    r = 8'h08;
      4'd4:    r = 8'h10;
      4'd5:    r = 8'h20;
      4'd6:    r = 8'h40;
      4'd7:    r = 8'h80;
      4'd8:    r = 8'h1b;
      4'd9:    r = 8'h36;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic word_t rot_sub(input word_t w);
    word_t r;
    r = {w[23:0], w[31:24]};
    return {SBOX_TAB[r[31:24]], SBOX_TAB[r[23:16]], SBOX_TAB[r[15:8]], SBOX_TAB[r[7:0]]};
  endfunction

endpackage

// ----- rtl/core/aes128ke_word_unit.sv -----
`timescale 1ns / 1ps

module aes128ke_word_unit
  import aes128ke_pkg::*;
(
  input  word_t                 w_back4,
  input  word_t                 w_prev,
  input  logic                  rot_en,
  input  logic [RCON_IDX_W-1:0] rcon_idx,
  output word_t                 w_new
);

  word_t tmp;

  always_comb begin
    if (rot_en) begin
      tmp = rot_sub(w_prev) ^ {rcon(rcon_idx), 24'h000000};
    end else begin
      tmp = w_prev;
    end
    w_new = w_back4 ^ tmp;
  end

endmodule

// ----- rtl/core/aes128ke_seq.sv -----
`timescale 1ns / 1ps

module aes128ke_seq
  import aes128ke_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  output logic [IDX_W-1:0] idx,
  output seq_ctl_t         ctl
);

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (idx_r == LAST_IDX) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    busy         = 1'b0;
    ctl.load     = 1'b0;
    ctl.emit     = 1'b0;
    ctl.last     = (idx_r == LAST_IDX);
    ctl.rot_en   = (idx_r[1:0] == 2'b00);
    ctl.rcon_idx = idx_r[IDX_W-1:2];
    idx_nxt      = idx_r;
    case (state_r)
      ST_IDLE: begin
        ctl.load = start;
        idx_nxt  = '0;
      end
      ST_EMIT: begin
        busy     = 1'b1;
        ctl.emit = 1'b1;
        idx_nxt  = idx_r + IDX_W'(1);
      end
      default: begin
        idx_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  assign idx = idx_r;

endmodule

// ----- rtl/core/aes128_key_expansion_core.sv -----
`timescale 1ns / 1ps

// AES-128 key schedule. Pulse start while busy is low to load a key; busy rises
// the next cycle and the 44 schedule words follow on consecutive cycles, one per
// out_valid pulse, word 0 first, out_last_word marking word 43. The receiver
// cannot stall, so it must take every word in the cycle it appears. Each key
// passes through the single word unit one word at a time (one S-box/XOR step
// per word), after which the block returns to idle to take the next start.

module aes128_key_expansion_core
  import aes128ke_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [63:0]      in_key_upper,
  input  logic [63:0]      in_key_lower,
  output logic             out_valid,
  output logic [IDX_W-1:0] out_word_index,
  output word_t            out_schedule_word,
  output logic             out_last_word
);

  seq_ctl_t         ctl;
  logic [IDX_W-1:0] idx;
  word_t            win_r [4];
  word_t            w_new;

  logic             out_valid_r;
  logic [IDX_W-1:0] out_word_index_r;
  word_t            out_schedule_word_r;
  logic             out_last_word_r;

  aes128ke_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .idx   (idx),
    .ctl   (ctl)
  );

  // window holds words i-4..i-1 relative to the word being formed
  aes128ke_word_unit u_word (
    .w_back4  (win_r[0]),
    .w_prev   (win_r[3]),
    .rot_en   (ctl.rot_en),
    .rcon_idx (ctl.rcon_idx),
    .w_new    (w_new)
  );

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      win_r[0] <= in_key_upper[63:32];
      win_r[1] <= in_key_upper[31:0];
      win_r[2] <= in_key_lower[63:32];
      win_r[3] <= in_key_lower[31:0];
    end else if (ctl.emit) begin
      win_r[0] <= win_r[1];
      win_r[1] <= win_r[2];
      win_r[2] <= win_r[3];
      win_r[3] <= w_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      out_word_index_r    <= idx;
      out_schedule_word_r <= win_r[0];
      out_last_word_r     <= ctl.last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_word_index    = out_word_index_r;
  assign out_schedule_word = out_schedule_word_r;
  assign out_last_word     = out_last_word_r & out_valid_r;

  a_first_word: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 (out_valid && out_word_index == '0))
    else $error("word 0 not emitted after item accept");

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_word |-> (out_valid && out_word_index == LAST_IDX))
    else $error("last word flag on wrong index");

  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_word) |=>
      (out_valid && out_word_index == $past(out_word_index) + IDX_W'(1)))
    else $error("schedule words not consecutive");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_word |-> !busy)
    else $error("busy still high after last word");

endmodule
